[design/tsf_pkg.sv]
// Package for the text stream character filter.
// Holds the channel payload types, the queue command type, register codes and byte constants.
// No dependencies.
`default_nettype none

package tsf_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       file_start;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } t_out;

    typedef struct packed {
        logic [6:0] stage_enables;
        logic [7:0] delete_char;
        logic [7:0] replace_from;
        logic [7:0] replace_to;
        logic [5:0] tab_width;
    } t_cfg;

    // One classified item as the back end needs it.
    typedef struct packed {
        logic       number_line;
        logic [7:0] tab_spaces;
        logic [7:0] ch;
    } t_cmd;

    localparam int CFG_INDEX_W = 3;

    localparam logic [CFG_INDEX_W-1:0] CFG_STAGE_ENABLES = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DELETE_CHAR   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_REPLACE_FROM  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_REPLACE_TO    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_TAB_WIDTH     = 3'd4;

    localparam logic [5:0] TAB_WIDTH_RESET = 6'd8;

    localparam int EN_DELETE_BIT  = 0;
    localparam int EN_REPLACE_BIT = 1;
    localparam int EN_UPPER_BIT   = 2;
    localparam int EN_LOWER_BIT   = 3;
    localparam int EN_NUMBER_BIT  = 4;
    localparam int EN_BLANK_BIT   = 5;
    localparam int EN_TABS_BIT    = 6;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_DELTA = 8'h20;

endpackage

`default_nettype wire

[design/tsf_front.sv]
// Front end of the text stream character filter: takes items, runs the byte stages,
// tracks the previous byte and the file start flag, and pushes commands into the queue.
// Depends on tsf_pkg.
`default_nettype none

module tsf_front
    import tsf_pkg::*;
#(
    parameter int MAX_TAB_WIDTH = 32
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_stall,
    input  wire t_in  i_data,
    input  wire t_cfg i_cfg,
    input  wire logic i_queue_full,
    output logic      o_push,
    output t_cmd      o_cmd
);

    logic [7:0] r_prev;
    logic       r_fsp;
    logic       r_count_nz;

    logic [7:0] n_prev;
    logic       n_fsp;
    logic       n_count_nz;

    logic       accept;
    logic       fsp_now;
    logic [7:0] prev_now;
    logic [7:0] c;
    logic [7:0] tab_w;
    logic       number_now;
    logic [7:0] tabs_now;
    logic [6:0] en;

    assign en      = i_cfg.stage_enables;
    assign o_stall = i_queue_full;
    assign accept  = i_valid && !i_queue_full;

    assign tab_w = ({2'b00, i_cfg.tab_width} > 8'(MAX_TAB_WIDTH)) ?
                   8'(MAX_TAB_WIDTH) : {2'b00, i_cfg.tab_width};

    always_comb begin
        fsp_now  = r_fsp || i_data.file_start;
        prev_now = i_data.file_start ? CH_NUL : r_prev;
        c        = i_data.in_byte;
        tabs_now = 8'd0;

        if (en[EN_DELETE_BIT] && c == i_cfg.delete_char) begin
            c = CH_NUL;
        end
        if (en[EN_REPLACE_BIT] && c != CH_NUL && c == i_cfg.replace_from) begin
            c = i_cfg.replace_to;
        end
        if (en[EN_UPPER_BIT] && c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
            c = c - CASE_DELTA;
        end
        if (en[EN_LOWER_BIT] && c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
            c = c + CASE_DELTA;
        end

        number_now = en[EN_NUMBER_BIT] && c != CH_NUL &&
                     (!r_count_nz || prev_now == CH_NL || fsp_now);
        n_fsp      = number_now ? 1'b0 : fsp_now;
        n_count_nz = r_count_nz || number_now;

        if (en[EN_BLANK_BIT] && c == CH_NL && prev_now == CH_NL) begin
            c = CH_NUL;
        end

        n_prev = prev_now;
        if (en[EN_TABS_BIT]) begin
            if (c == CH_TAB) begin
                tabs_now = tab_w;
                c        = CH_NUL;
            end
            if (c == CH_NUL) begin
                n_prev = CH_NUL;
            end
        end
        if (c != CH_NUL) begin
            n_prev = c;
        end
    end

    // Items that yield nothing still update the state but never reach the queue.
    assign o_push = accept && (number_now || tabs_now != 8'd0 || c != CH_NUL);
    assign o_cmd  = '{number_line: number_now, tab_spaces: tabs_now, ch: c};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev     <= CH_NUL;
            r_fsp      <= 1'b0;
            r_count_nz <= 1'b0;
        end else if (accept) begin
            r_prev     <= n_prev;
            r_fsp      <= n_fsp;
            r_count_nz <= n_count_nz;
        end
    end

endmodule

`default_nettype wire

[design/tsf_queue.sv]
// Two-entry command queue between the front and back ends of the filter.
// Depends on tsf_pkg.
`default_nettype none

module tsf_queue
    import tsf_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_cmd      o_cmd
);

    t_cmd       r_entry [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    logic       do_push;
    logic       do_pop;

    assign o_full  = r_count == 2'd2;
    assign o_valid = r_count != 2'd0;
    assign o_cmd   = r_entry[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 2'd1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

[design/tsf_back.sv]
// Back end of the filter: expands each queued command into output bytes (line number
// prefix, separator, tab spaces, the byte itself) and keeps the BCD line counter.
// Depends on tsf_pkg.
`default_nettype none

module tsf_back
    import tsf_pkg::*;
#(
    parameter int LINE_DIGITS = 6
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_q_valid,
    input  wire t_cmd i_q_cmd,
    output logic      o_pop,
    output logic      o_busy,
    output logic      o_valid,
    input  wire logic i_stall,
    output t_out      o_data
);

    localparam int BCD_W = 4 * LINE_DIGITS;
    localparam int IDX_W = (LINE_DIGITS > 1) ? $clog2(LINE_DIGITS) : 1;
    localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(LINE_DIGITS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIGIT,
        S_SEP,
        S_TAB,
        S_CHAR
    } t_state;

    t_state           r_state;
    t_cmd             r_cmd;
    logic [BCD_W-1:0] r_bcd;
    logic [IDX_W-1:0] r_idx;
    logic             r_lead;
    logic [7:0]       r_cnt;
    logic             r_ov;
    t_out             r_out;

    logic [BCD_W-1:0] n_bcd;
    logic             all_nines;
    logic             carry;
    logic [3:0]       digit;
    logic             lead_now;
    logic             emit;
    logic             adv;
    logic             step;
    logic             load;
    logic [7:0]       cur_byte;
    logic             cur_last;

    // Saturating BCD increment.
    always_comb begin
        n_bcd     = r_bcd;
        all_nines = 1'b1;
        carry     = 1'b1;
        for (int i = 0; i < LINE_DIGITS; i++) begin
            if (r_bcd[4*i +: 4] != 4'd9) begin
                all_nines = 1'b0;
            end
            if (carry) begin
                if (r_bcd[4*i +: 4] >= 4'd9) begin
                    n_bcd[4*i +: 4] = 4'd0;
                end else begin
                    n_bcd[4*i +: 4] = r_bcd[4*i +: 4] + 4'd1;
                    carry           = 1'b0;
                end
            end
        end
        if (all_nines) begin
            n_bcd = r_bcd;
        end
    end

    assign digit    = r_bcd[4*r_idx +: 4];
    assign lead_now = r_lead && digit == 4'd0 && r_idx != '0;

    always_comb begin
        cur_byte = CH_SPACE;
        cur_last = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                cur_byte = CH_SPACE;
                cur_last = 1'b0;
            end
            S_DIGIT: begin
                cur_byte = lead_now ? CH_SPACE : (CH_ZERO + {4'd0, digit});
                cur_last = 1'b0;
            end
            S_SEP: begin
                cur_byte = CH_SPACE;
                cur_last = r_cnt == 8'd1 && r_cmd.tab_spaces == 8'd0 && r_cmd.ch == CH_NUL;
            end
            S_TAB: begin
                cur_byte = CH_SPACE;
                cur_last = r_cnt == 8'd1 && r_cmd.ch == CH_NUL;
            end
            S_CHAR: begin
                cur_byte = r_cmd.ch;
                cur_last = 1'b1;
            end
            default: begin
                cur_byte = CH_SPACE;
                cur_last = 1'b0;
            end
        endcase
    end

    assign emit   = r_state != S_IDLE;
    assign adv    = !r_ov || !i_stall;
    assign step   = emit && adv;
    assign load   = i_q_valid && (r_state == S_IDLE || (step && cur_last));
    assign o_pop  = load;
    assign o_busy = emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_bcd   <= '0;
            r_ov    <= 1'b0;
            r_idx   <= '0;
            r_lead  <= 1'b0;
            r_cnt   <= 8'd0;
        end else begin
            if (adv) begin
                r_ov  <= emit;
                r_out <= '{out_byte: cur_byte, last: cur_last};
            end

            if (load) begin
                r_cmd <= i_q_cmd;
                if (i_q_cmd.number_line) begin
                    r_bcd   <= n_bcd;
                    r_state <= S_DIGIT;
                    r_idx   <= IDX_TOP;
                    r_lead  <= 1'b1;
                end else if (i_q_cmd.tab_spaces != 8'd0) begin
                    r_state <= S_TAB;
                    r_cnt   <= i_q_cmd.tab_spaces;
                end else begin
                    r_state <= S_CHAR;
                end
            end else if (step) begin
                unique case (r_state)
                    S_IDLE: begin
                        r_state <= S_IDLE;
                    end
                    S_DIGIT: begin
                        if (r_idx == '0) begin
                            r_state <= S_SEP;
                            r_cnt   <= 8'd2;
                        end else begin
                            r_idx  <= r_idx - IDX_W'(1);
                            r_lead <= lead_now;
                        end
                    end
                    S_SEP: begin
                        if (r_cnt != 8'd1) begin
                            r_cnt <= r_cnt - 8'd1;
                        end else if (r_cmd.tab_spaces != 8'd0) begin
                            r_state <= S_TAB;
                            r_cnt   <= r_cmd.tab_spaces;
                        end else if (r_cmd.ch != CH_NUL) begin
                            r_state <= S_CHAR;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                    S_TAB: begin
                        if (r_cnt != 8'd1) begin
                            r_cnt <= r_cnt - 8'd1;
                        end else if (r_cmd.ch != CH_NUL) begin
                            r_state <= S_CHAR;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                    S_CHAR: begin
                        r_state <= S_IDLE;
                    end
                    default: begin
                        r_state <= S_IDLE;
                    end
                endcase
            end
        end
    end

    assign o_valid = r_ov;
    assign o_data  = r_out;

endmodule

`default_nettype wire

[design/text_stream_char_filter_top.sv]
// Top level of the text stream character filter: configuration registers, front end,
// command queue and back end. Depends on tsf_pkg, tsf_front, tsf_queue and tsf_back.
`default_nettype none

// Text bytes enter one per cycle and run through delete, replace, upper and lower case,
// line numbering, blank line dropping and tab expansion as enabled in stage_enables.
// The front end classifies an input item in the cycle it is taken and keeps going as
// long as the two-entry command queue has room; the back end sets the rate, emitting one
// output byte per cycle while the output is not stalled: a numbered line adds LINE_DIGITS
// digits and two separator spaces, and a tab expands to min(tab_width, MAX_TAB_WIDTH)
// spaces. After the back end has run dry, the next queued command is first loaded while
// idle before its bytes are emitted. Items that produce no output never enter the queue.
// Every output byte carries last on the final byte of its input item. Configuration is
// written through a separate port that is always ready; indexes above 4 are ignored.
module text_stream_char_filter_top
    import tsf_pkg::*;
#(
    parameter int MAX_TAB_WIDTH = 32,
    parameter int LINE_DIGITS   = 6
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire t_in                    i_in_data,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output t_out                        o_out_data,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [7:0]             i_cfg_data
);

    t_cfg r_cfg;

    logic w_push;
    t_cmd w_push_cmd;
    logic w_q_full;
    logic w_q_valid;
    t_cmd w_q_cmd;
    logic w_pop;
    logic w_back_busy;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{stage_enables: 7'd0, delete_char: 8'd0, replace_from: 8'd0,
                       replace_to: 8'd0, tab_width: TAB_WIDTH_RESET};
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_STAGE_ENABLES: r_cfg.stage_enables <= i_cfg_data[6:0];
                CFG_DELETE_CHAR:   r_cfg.delete_char   <= i_cfg_data;
                CFG_REPLACE_FROM:  r_cfg.replace_from  <= i_cfg_data;
                CFG_REPLACE_TO:    r_cfg.replace_to    <= i_cfg_data;
                CFG_TAB_WIDTH:     r_cfg.tab_width     <= i_cfg_data[5:0];
                default: begin
                end
            endcase
        end
    end

    tsf_front #(
        .MAX_TAB_WIDTH(MAX_TAB_WIDTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_stall      (o_in_stall),
        .i_data       (i_in_data),
        .i_cfg        (r_cfg),
        .i_queue_full (w_q_full),
        .o_push       (w_push),
        .o_cmd        (w_push_cmd)
    );

    tsf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd)
    );

    tsf_back #(
        .LINE_DIGITS(LINE_DIGITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_cmd   (w_q_cmd),
        .o_pop     (w_pop),
        .o_busy    (w_back_busy),
        .o_valid   (o_out_valid),
        .i_stall   (i_out_stall),
        .o_data    (o_out_data)
    );

    // A command pushed by the front end is visible to the back end in the next cycle.
    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |=> w_q_valid)
        else $error("pushed command missing from queue");

    // An output item can only appear if the back end was working on a command.
    a_no_phantom_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_back_busy && !w_q_valid) |=> !$rose(o_out_valid))
        else $error("output item without a command");

    // The back end never takes a command from an empty queue.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_valid)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

[tb/text_stream_char_filter_top_tb.sv]
// Self-checking testbench for text_stream_char_filter_top: a directed table, then random
// text under several idling patterns, each byte checked against typed text or a filter model.
// Depends on tsf_pkg and text_stream_char_filter_top.
`timescale 1ns / 1ps

module text_stream_char_filter_top_tb;
    import tsf_pkg::*;

    localparam int MAX_TAB_WIDTH = 32;
    localparam int LINE_DIGITS   = 6;
    localparam int DRAIN_CYCLES  = 12;
    localparam int HOLD_CYCLES   = 200;
    localparam int PHASE_ITEMS   = 50;
    localparam int NUM_PHASES    = 6;

    localparam logic [7:0] EN_DEL   = 8'(1 << EN_DELETE_BIT);
    localparam logic [7:0] EN_REPL  = 8'(1 << EN_REPLACE_BIT);
    localparam logic [7:0] EN_UPPER = 8'(1 << EN_UPPER_BIT);
    localparam logic [7:0] EN_LOWER = 8'(1 << EN_LOWER_BIT);
    localparam logic [7:0] EN_NUM   = 8'(1 << EN_NUMBER_BIT);
    localparam logic [7:0] EN_BLANK = 8'(1 << EN_BLANK_BIT);
    localparam logic [7:0] EN_TABS  = 8'(1 << EN_TABS_BIT);
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = CFG_INDEX_W'(CFG_TAB_WIDTH + 1);

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind  kind;
        logic [7:0] code;   // text byte, or register index
        logic [7:0] arg;    // file start flag, or register data
        bit         typed;
        string      want;
    } t_dir_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_stall;
    t_in                    i_in_data = '0;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    t_out                   o_out_data;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [7:0]             i_cfg_data = '0;

    // Model copy of the configuration and the filter state.
    logic [6:0]  m_en;
    logic [7:0]  m_del;
    logic [7:0]  m_from;
    logic [7:0]  m_to;
    logic [5:0]  m_tabw;
    logic [23:0] m_count;
    logic [7:0]  m_prev;
    logic        m_fs_pend;

    t_out     model_bytes[$];
    t_out     filtered_bytes_q[$];
    t_dir_row dir_rows[$];

    int fail_count    = 0;
    int send_idle_pct = 0;
    int rcv_stall_pct = 0;
    int hold_left     = 0;
    bit hold_req      = 1'b0;

    text_stream_char_filter_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #20_000_000;
        $display("FAIL text_stream_char_filter_top");
        $finish;
    end

    // Receiver: random stalling, or a long hold-off when one is requested.
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < rcv_stall_pct);
        end
    end

    // Output values are sampled at the falling edge, so they are settled for the rising edge
    // at which the byte is taken.
    always begin : out_check
        bit   seen;
        t_out got;
        t_out want;
        @(negedge i_clk);
        seen = i_rst_n && o_out_valid && !i_out_stall;
        got = o_out_data;
        @(posedge i_clk);
        if (seen) begin
            if (filtered_bytes_q.size() == 0) begin
                $error("out_byte: expected nothing, got %h", got.out_byte);
                fail_count++;
            end else begin
                want = filtered_bytes_q.pop_front();
                if (got.out_byte !== want.out_byte) begin
                    $error("out_byte: expected %h, got %h", want.out_byte, got.out_byte);
                    fail_count++;
                end
                if (got.last !== want.last) begin
                    $error("last: expected %b, got %b", want.last, got.last);
                    fail_count++;
                end
            end
        end
    end

    function automatic void emit_byte(logic [7:0] b);
        t_out r;
        r.out_byte = b;
        r.last = 1'b0;
        model_bytes.push_back(r);
    endfunction

    // Runs one item through the enabled stages and leaves its output bytes in model_bytes.
    function automatic void filter_byte(t_in item);
        logic [7:0] c;
        logic [3:0] d;
        bit         lead;
        bit         carry;
        int         w;
        model_bytes.delete();
        c = item.in_byte;
        if (item.file_start) begin
            m_prev = CH_NUL;
            m_fs_pend = 1'b1;
        end
        if (m_en[EN_DELETE_BIT] && c == m_del)
            c = CH_NUL;
        if (m_en[EN_REPLACE_BIT] && c != CH_NUL && c == m_from)
            c = m_to;
        if (m_en[EN_UPPER_BIT] && c >= CH_LOWER_A && c <= CH_LOWER_Z)
            c = c - CASE_DELTA;
        if (m_en[EN_LOWER_BIT] && c >= CH_UPPER_A && c <= CH_UPPER_Z)
            c = c + CASE_DELTA;
        if (m_en[EN_NUMBER_BIT] && c != CH_NUL &&
            (m_count == '0 || m_prev == CH_NL || m_fs_pend)) begin
            // BCD increment that holds at all nines.
            if (m_count != 24'h999999) begin
                carry = 1'b1;
                for (int i = 0; i < LINE_DIGITS; i++) begin
                    if (carry) begin
                        if (m_count[4*i +: 4] == 4'd9) begin
                            m_count[4*i +: 4] = 4'd0;
                        end else begin
                            m_count[4*i +: 4] = m_count[4*i +: 4] + 4'd1;
                            carry = 1'b0;
                        end
                    end
                end
            end
            lead = 1'b1;
            for (int i = LINE_DIGITS - 1; i >= 0; i--) begin
                d = m_count[4*i +: 4];
                if (d != 4'd0 || i == 0)
                    lead = 1'b0;
                emit_byte(lead ? CH_SPACE : CH_ZERO + {4'd0, d});
            end
            emit_byte(CH_SPACE);
            emit_byte(CH_SPACE);
            m_fs_pend = 1'b0;
        end
        if (m_en[EN_BLANK_BIT] && c == CH_NL && m_prev == CH_NL)
            c = CH_NUL;
        if (m_en[EN_TABS_BIT]) begin
            if (c == CH_TAB) begin
                w = (m_tabw > MAX_TAB_WIDTH) ? MAX_TAB_WIDTH : int'(m_tabw);
                repeat (w) emit_byte(CH_SPACE);
                c = CH_NUL;
            end
            if (c == CH_NUL)
                m_prev = CH_NUL;
        end
        if (c != CH_NUL) begin
            emit_byte(c);
            m_prev = c;
        end
        if (model_bytes.size() > 0)
            model_bytes[model_bytes.size() - 1].last = 1'b1;
    endfunction

    task automatic send_item(input t_in item, input bit typed, input string want);
        bit   acc;
        t_out r;
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_in_data <= item;
        do begin
            @(negedge i_clk);
            acc = !o_in_stall;
            if (acc) begin
                filter_byte(item);
                if (typed) begin
                    for (int i = 0; i < want.len(); i++) begin
                        r.out_byte = want[i];
                        r.last = (i == want.len() - 1);
                        filtered_bytes_q.push_back(r);
                    end
                end else begin
                    foreach (model_bytes[i])
                        filtered_bytes_q.push_back(model_bytes[i]);
                end
            end
            @(posedge i_clk);
        end while (!acc);
    endtask

    // Stops offering items and waits until every expected byte is out and the block is quiet.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (filtered_bytes_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Leaves valid high so that back-to-back writes need no gap; the caller lowers it.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
        bit acc;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do begin
            @(negedge i_clk);
            acc = o_cfg_ready;
            @(posedge i_clk);
        end while (!acc);
        case (idx)
            CFG_STAGE_ENABLES: m_en = val[6:0];
            CFG_DELETE_CHAR:   m_del = val;
            CFG_REPLACE_FROM:  m_from = val;
            CFG_REPLACE_TO:    m_to = val;
            CFG_TAB_WIDTH:     m_tabw = val[5:0];
            default: ;
        endcase
    endtask

    task automatic add_item(input logic [7:0] b, input logic fs, input bit typed,
                            input string want);
        t_dir_row row;
        row.kind = ROW_ITEM;
        row.code = b;
        row.arg = {7'd0, fs};
        row.typed = typed;
        row.want = want;
        dir_rows.push_back(row);
    endtask

    task automatic add_cfg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
        t_dir_row row;
        row.kind = ROW_CFG;
        row.code = {5'd0, idx};
        row.arg = val;
        row.typed = 1'b0;
        row.want = "";
        dir_rows.push_back(row);
    endtask

    function automatic t_in random_text();
        t_in        item;
        int         r;
        r = $urandom_range(99);
        if (r < 50)
            item.in_byte = ($urandom_range(1) ? CH_LOWER_A : CH_UPPER_A) + 8'($urandom_range(25));
        else if (r < 60)
            item.in_byte = CH_SPACE;
        else if (r < 71)
            item.in_byte = CH_NL;
        else if (r < 79)
            item.in_byte = CH_TAB;
        else if (r < 85)
            item.in_byte = $urandom_range(1) ? m_del : m_from;
        else if (r < 90)
            item.in_byte = CH_NUL;
        else
            item.in_byte = 8'($urandom_range(255));
        item.file_start = ($urandom_range(24) == 0);
        return item;
    endfunction

    function automatic logic [7:0] random_target();
        if ($urandom_range(3) == 0)
            return 8'($urandom_range(255));
        return CH_LOWER_A + 8'($urandom_range(25));
    endfunction

    initial begin : main
        bit         cfg_busy;
        t_in        item;
        logic [7:0] tw;
        m_en = '0;
        m_del = '0;
        m_from = '0;
        m_to = '0;
        m_tabw = TAB_WIDTH_RESET;
        m_count = '0;
        m_prev = CH_NUL;
        m_fs_pend = 1'b0;

        // Reset values, byte extremes and the empty zero byte.
        add_item("A", 1'b0, 1'b1, "A");
        add_item(8'hFF, 1'b0, 1'b0, "");
        add_item(CH_NUL, 1'b0, 1'b1, "");
        add_item(8'h7F, 1'b1, 1'b0, "");
        // Line numbering and tabs; a zero byte with file start still starts a new line.
        add_cfg(CFG_STAGE_ENABLES, EN_NUM | EN_TABS);
        add_cfg(CFG_TAB_WIDTH, 8'd3);
        add_item("x", 1'b1, 1'b1, "     1  x");
        add_item(CH_TAB, 1'b0, 1'b1, "   ");
        add_item(CH_NL, 1'b0, 1'b1, "\n");
        add_item("y", 1'b0, 1'b1, "     2  y");
        add_item(CH_NUL, 1'b1, 1'b1, "");
        add_item("z", 1'b0, 1'b1, "     3  z");
        // Delete, replace by zero, both case stages and blank line dropping.
        add_cfg(CFG_STAGE_ENABLES, EN_DEL | EN_REPL | EN_UPPER | EN_LOWER | EN_BLANK);
        add_cfg(CFG_DELETE_CHAR, "q");
        add_cfg(CFG_REPLACE_FROM, "a");
        add_cfg(CFG_REPLACE_TO, CH_NUL);
        add_item("q", 1'b0, 1'b1, "");
        add_item("a", 1'b0, 1'b1, "");
        add_item("b", 1'b0, 1'b1, "b");
        add_item("B", 1'b0, 1'b1, "b");
        add_item(CH_NL, 1'b0, 1'b1, "\n");
        add_item(CH_NL, 1'b0, 1'b1, "");
        add_item(8'hE1, 1'b0, 1'b0, "");
        // Everything enabled, register extremes, a wide tab giving the longest burst.
        add_cfg(CFG_REPLACE_TO, 8'hFF);
        add_cfg(CFG_REPLACE_FROM, CH_NUL);
        add_cfg(CFG_DELETE_CHAR, 8'hFF);
        add_cfg(CFG_STAGE_ENABLES, 8'hFF);
        add_cfg(CFG_TAB_WIDTH, 8'hFF);
        add_item(CH_NUL, 1'b0, 1'b0, "");
        add_item(8'hFF, 1'b0, 1'b0, "");
        add_item(CH_TAB, 1'b1, 1'b0, "");
        add_item(CH_NL, 1'b0, 1'b0, "");
        // A zero tab width, and writes to unused indexes that must change nothing.
        add_cfg(CFG_TAB_WIDTH, 8'd0);
        add_cfg(CFG_SPARE, 8'hAA);
        add_cfg(CFG_INDEX_W'(CFG_SPARE + 2), 8'h55);
        add_item(CH_TAB, 1'b0, 1'b0, "");
        add_item("m", 1'b0, 1'b0, "");

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 21;
        rcv_stall_pct = 21;
        cfg_busy = 1'b0;
        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                if (!cfg_busy) begin
                    wait_drained();
                    cfg_busy = 1'b1;
                end
                write_reg(dir_rows[i].code[CFG_INDEX_W-1:0], dir_rows[i].arg);
            end else begin
                if (cfg_busy) begin
                    i_cfg_valid <= 1'b0;
                    cfg_busy = 1'b0;
                end
                item.in_byte = dir_rows[i].code;
                item.file_start = dir_rows[i].arg[0];
                send_item(item, dir_rows[i].typed, dir_rows[i].want);
            end
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_drained();
            if ($urandom_range(5) == 0)
                tw = 8'($urandom_range(63));
            else
                tw = 8'($urandom_range(10));
            write_reg(CFG_STAGE_ENABLES, 8'($urandom_range(255)) | ((ph % 2) ? EN_NUM : 8'd0));
            write_reg(CFG_DELETE_CHAR, random_target());
            write_reg(CFG_REPLACE_FROM, random_target());
            write_reg(CFG_REPLACE_TO, $urandom_range(3) == 0 ? CH_NUL : random_target());
            write_reg(CFG_TAB_WIDTH, tw);
            write_reg(CFG_INDEX_W'($urandom_range(7, CFG_SPARE)), 8'($urandom_range(255)));
            i_cfg_valid <= 1'b0;
            case (ph)
                0, 4: begin
                    send_idle_pct = 0;
                    rcv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 87;
                    rcv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    rcv_stall_pct = 87;
                end
                default: begin
                    send_idle_pct = 21;
                    rcv_stall_pct = 21;
                end
            endcase
            // The receiver holds off while items keep coming, so the queue fills up.
            if (ph == 0)
                hold_req = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_item(random_text(), 1'b0, "");
        end

        wait_drained();
        if (fail_count == 0)
            $display("PASS text_stream_char_filter_top");
        else
            $display("FAIL text_stream_char_filter_top");
        $finish;
    end

endmodule

[text_stream_char_filter_top.f]
design/tsf_pkg.sv
design/tsf_front.sv
design/tsf_queue.sv
design/tsf_back.sv
design/text_stream_char_filter_top.sv
tb/text_stream_char_filter_top_tb.sv
